/* hw/rtl/jpp_pkg.sv */
package jpp_pkg;

  localparam int LEVEL_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUT   = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_OBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CBRK   = 8'h5D;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_OBRACE = 8'h7B;
  localparam logic [7:0] CH_CBRACE = 8'h7D;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SYNTAX  = 3'd1,
    ST_NUMBER  = 3'd2,
    ST_DEPTH   = 3'd3,
    ST_OUT_OVF = 3'd4,
    ST_IN_OVF  = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    M_TOP        = 5'd0,
    M_ARR_FIRST  = 5'd1,
    M_OBJ_FIRST  = 5'd2,
    M_VALUE      = 5'd3,
    M_KEY        = 5'd4,
    M_STR        = 5'd5,
    M_STR_ESC    = 5'd6,
    M_KEYSTR     = 5'd7,
    M_KEYSTR_ESC = 5'd8,
    M_COLON      = 5'd9,
    M_AFTER      = 5'd10,
    M_DONE       = 5'd11,
    M_NULL_U     = 5'd12,
    M_NULL_L1    = 5'd13,
    M_NULL_L2    = 5'd14,
    M_TRUE_R     = 5'd15,
    M_TRUE_U     = 5'd16,
    M_TRUE_E     = 5'd17,
    M_FALSE_A    = 5'd18,
    M_FALSE_L    = 5'd19,
    M_FALSE_S    = 5'd20,
    M_FALSE_E    = 5'd21,
    M_N_SIGN     = 5'd22,
    M_N_ZERO     = 5'd23,
    M_N_INT      = 5'd24,
    M_N_FRAC0    = 5'd25,
    M_N_FRAC     = 5'd26,
    M_N_EXP0     = 5'd27,
    M_N_EXPS     = 5'd28,
    M_N_EXP      = 5'd29
  } mode_t;

  // one decoded input byte: what to emit and how the parser state moves
  typedef struct packed {
    mode_t      mode_next;
    logic       redo;
    logic       err;
    status_t    err_code;
    logic       c0_en;
    logic [7:0] c0;
    logic       push;
    logic       push_kind;
    logic       pop;
    logic       depth_err;
    logic       nl_en;
    logic       c1_en;
    logic [7:0] c1;
    logic       is_close;
  } dec_t;

endpackage

/* hw/rtl/jpp_if.sv */
interface jpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface

interface jpp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_last;
  logic [2:0] status;
  logic       value_done;

  modport source (output valid, output out_char, output is_last, output status,
                  output value_done, input ready);
  modport sink (input valid, input out_char, input is_last, input status,
                input value_done, output ready);
endinterface

/* hw/rtl/jpp_ram.sv */
module jpp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/jpp_decode.sv */
module jpp_decode (
  input  logic [7:0]                    ch,
  input  jpp_pkg::mode_t                mode,
  input  logic [jpp_pkg::LEVEL_W-1:0]   level,
  input  logic [jpp_pkg::LEVEL_W-1:0]   lim,
  input  logic                          kind,
  input  logic                          full,
  output jpp_pkg::dec_t                 dec
);

  function automatic jpp_pkg::mode_t complete_mode(logic [jpp_pkg::LEVEL_W-1:0] lv);
    return (lv == '0) ? jpp_pkg::M_DONE : jpp_pkg::M_AFTER;
  endfunction

  function automatic jpp_pkg::dec_t value_start(jpp_pkg::dec_t din, logic [7:0] c,
                                                logic deep);
    jpp_pkg::dec_t d;
    d = din;
    d.c0 = c;
    d.c0_en = 1'b1;
    if (c == jpp_pkg::CH_OBRACE || c == jpp_pkg::CH_OBRK) begin
      if (deep) begin
        d.depth_err = 1'b1;
      end else begin
        d.push = 1'b1;
        d.push_kind = (c == jpp_pkg::CH_OBRACE);
        d.mode_next = (c == jpp_pkg::CH_OBRACE) ? jpp_pkg::M_OBJ_FIRST
                                                : jpp_pkg::M_ARR_FIRST;
        d.nl_en = 1'b1;
      end
    end else if (c == jpp_pkg::CH_QUOTE) begin
      d.mode_next = jpp_pkg::M_STR;
    end else if (c == jpp_pkg::CH_N) begin
      d.mode_next = jpp_pkg::M_NULL_U;
    end else if (c == jpp_pkg::CH_T) begin
      d.mode_next = jpp_pkg::M_TRUE_R;
    end else if (c == jpp_pkg::CH_F) begin
      d.mode_next = jpp_pkg::M_FALSE_A;
    end else if (c == jpp_pkg::CH_MINUS) begin
      d.mode_next = jpp_pkg::M_N_SIGN;
    end else if (c == jpp_pkg::CH_ZERO) begin
      d.mode_next = jpp_pkg::M_N_ZERO;
    end else if (c >= jpp_pkg::CH_ZERO && c <= jpp_pkg::CH_NINE) begin
      d.mode_next = jpp_pkg::M_N_INT;
    end else begin
      d.c0_en = 1'b0;
      d.err = 1'b1;
      d.err_code = jpp_pkg::ST_NUMBER;
    end
    return d;
  endfunction

  function automatic jpp_pkg::dec_t close_cont(jpp_pkg::dec_t din, logic k,
                                               logic [jpp_pkg::LEVEL_W-1:0] lv);
    jpp_pkg::dec_t d;
    d = din;
    d.pop = 1'b1;
    d.nl_en = 1'b1;
    d.c1_en = 1'b1;
    d.c1 = k ? jpp_pkg::CH_CBRACE : jpp_pkg::CH_CBRK;
    d.is_close = 1'b1;
    d.mode_next = (lv == jpp_pkg::LEVEL_W'(1)) ? jpp_pkg::M_DONE : jpp_pkg::M_AFTER;
    return d;
  endfunction

  logic       dig;
  logic       expo;
  logic       ws;
  logic       deep;
  logic [7:0] lit_exp;
  logic       lit_end;
  jpp_pkg::status_t syn_code;

  always_comb begin
    dig = (ch >= jpp_pkg::CH_ZERO) && (ch <= jpp_pkg::CH_NINE);
    expo = (ch == jpp_pkg::CH_E) || (ch == jpp_pkg::CH_UPPER_E);
    ws = (ch == jpp_pkg::CH_SPACE) || (ch == jpp_pkg::CH_TAB) || (ch == jpp_pkg::CH_NL) ||
         (ch == jpp_pkg::CH_VT) || (ch == jpp_pkg::CH_FF) || (ch == jpp_pkg::CH_CR);
    deep = (level >= lim);
    syn_code = full ? jpp_pkg::ST_OUT_OVF : jpp_pkg::ST_SYNTAX;

    lit_end = 1'b0;
    case (mode)
      jpp_pkg::M_NULL_U:  lit_exp = jpp_pkg::CH_U;
      jpp_pkg::M_NULL_L1: lit_exp = jpp_pkg::CH_L;
      jpp_pkg::M_NULL_L2: begin
        lit_exp = jpp_pkg::CH_L;
        lit_end = 1'b1;
      end
      jpp_pkg::M_TRUE_R:  lit_exp = jpp_pkg::CH_R;
      jpp_pkg::M_TRUE_U:  lit_exp = jpp_pkg::CH_U;
      jpp_pkg::M_TRUE_E: begin
        lit_exp = jpp_pkg::CH_E;
        lit_end = 1'b1;
      end
      jpp_pkg::M_FALSE_A: lit_exp = jpp_pkg::CH_A;
      jpp_pkg::M_FALSE_L: lit_exp = jpp_pkg::CH_L;
      jpp_pkg::M_FALSE_S: lit_exp = jpp_pkg::CH_S;
      jpp_pkg::M_FALSE_E: begin
        lit_exp = jpp_pkg::CH_E;
        lit_end = 1'b1;
      end
      default: lit_exp = jpp_pkg::CH_NUL;
    endcase

    dec = '0;
    dec.mode_next = mode;
    dec.c0 = ch;

    if (mode inside {[jpp_pkg::M_N_SIGN:jpp_pkg::M_N_EXP]}) begin
      // number grammar; a byte that ends the number falls to the bottom
      dec.c0_en = 1'b1;
      case (mode)
        jpp_pkg::M_N_SIGN, jpp_pkg::M_N_FRAC0, jpp_pkg::M_N_EXPS: begin
          if (!dig) begin
            dec.c0_en = 1'b0;
            dec.err = 1'b1;
            dec.err_code = jpp_pkg::ST_NUMBER;
          end else if (mode == jpp_pkg::M_N_SIGN) begin
            dec.mode_next = (ch == jpp_pkg::CH_ZERO) ? jpp_pkg::M_N_ZERO : jpp_pkg::M_N_INT;
          end else if (mode == jpp_pkg::M_N_FRAC0) begin
            dec.mode_next = jpp_pkg::M_N_FRAC;
          end else begin
            dec.mode_next = jpp_pkg::M_N_EXP;
          end
        end
        jpp_pkg::M_N_ZERO, jpp_pkg::M_N_INT: begin
          if (dig) begin
            if (mode == jpp_pkg::M_N_ZERO) begin
              dec.c0_en = 1'b0;
              dec.err = 1'b1;
              dec.err_code = jpp_pkg::ST_NUMBER;
            end
          end else if (ch == jpp_pkg::CH_DOT) begin
            dec.mode_next = jpp_pkg::M_N_FRAC0;
          end else if (expo) begin
            dec.mode_next = jpp_pkg::M_N_EXP0;
          end else begin
            dec.c0_en = 1'b0;
          end
        end
        jpp_pkg::M_N_FRAC: begin
          if (expo) begin
            dec.mode_next = jpp_pkg::M_N_EXP0;
          end else if (!dig) begin
            dec.c0_en = 1'b0;
          end
        end
        jpp_pkg::M_N_EXP0: begin
          if (ch == jpp_pkg::CH_PLUS || ch == jpp_pkg::CH_MINUS) begin
            dec.mode_next = jpp_pkg::M_N_EXPS;
          end else if (!dig) begin
            dec.c0_en = 1'b0;
            dec.err = 1'b1;
            dec.err_code = jpp_pkg::ST_NUMBER;
          end else begin
            dec.mode_next = jpp_pkg::M_N_EXP;
          end
        end
        default: begin
          if (!dig) begin
            dec.c0_en = 1'b0;
          end
        end
      endcase
      if (!dec.c0_en && !dec.err) begin
        // number ended: at top level the text is finished, else reparse
        dec.mode_next = complete_mode(level);
        dec.redo = (level != '0);
      end
    end else if (mode inside {[jpp_pkg::M_NULL_U:jpp_pkg::M_FALSE_E]}) begin
      if (ch != lit_exp) begin
        dec.err = 1'b1;
        dec.err_code = syn_code;
      end else begin
        dec.c0_en = 1'b1;
        dec.mode_next = lit_end ? complete_mode(level) : jpp_pkg::mode_t'(mode + 5'd1);
      end
    end else begin
      case (mode)
        jpp_pkg::M_STR, jpp_pkg::M_KEYSTR: begin
          dec.c0_en = 1'b1;
          if (ch == jpp_pkg::CH_BSLASH) begin
            dec.mode_next = jpp_pkg::mode_t'(mode + 5'd1);
          end else if (ch == jpp_pkg::CH_QUOTE) begin
            dec.mode_next = (mode == jpp_pkg::M_STR) ? complete_mode(level)
                                                     : jpp_pkg::M_COLON;
          end
        end
        jpp_pkg::M_STR_ESC, jpp_pkg::M_KEYSTR_ESC: begin
          dec.c0_en = 1'b1;
          dec.mode_next = jpp_pkg::mode_t'(mode - 5'd1);
        end
        default: begin
          if (!ws) begin
            case (mode)
              jpp_pkg::M_TOP, jpp_pkg::M_VALUE: dec = value_start(dec, ch, deep);
              jpp_pkg::M_ARR_FIRST: begin
                if (ch == jpp_pkg::CH_CBRK) dec = close_cont(dec, kind, level);
                else dec = value_start(dec, ch, deep);
              end
              jpp_pkg::M_OBJ_FIRST, jpp_pkg::M_KEY: begin
                if (mode == jpp_pkg::M_OBJ_FIRST && ch == jpp_pkg::CH_CBRACE) begin
                  dec = close_cont(dec, kind, level);
                end else if (ch != jpp_pkg::CH_QUOTE) begin
                  dec.err = 1'b1;
                  dec.err_code = syn_code;
                end else begin
                  dec.c0_en = 1'b1;
                  dec.mode_next = jpp_pkg::M_KEYSTR;
                end
              end
              jpp_pkg::M_COLON: begin
                if (ch != jpp_pkg::CH_COLON) begin
                  dec.err = 1'b1;
                  dec.err_code = syn_code;
                end else begin
                  dec.c0_en = 1'b1;
                  dec.c1_en = 1'b1;
                  dec.c1 = jpp_pkg::CH_SPACE;
                  dec.mode_next = jpp_pkg::M_VALUE;
                end
              end
              jpp_pkg::M_AFTER: begin
                if (ch == (kind ? jpp_pkg::CH_CBRACE : jpp_pkg::CH_CBRK)) begin
                  dec = close_cont(dec, kind, level);
                end else if (ch != jpp_pkg::CH_COMMA) begin
                  dec.err = 1'b1;
                  dec.err_code = syn_code;
                end else begin
                  dec.c0_en = 1'b1;
                  dec.nl_en = 1'b1;
                  dec.mode_next = kind ? jpp_pkg::M_KEY : jpp_pkg::M_VALUE;
                end
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end
endmodule

/* hw/rtl/json_pretty_printer.sv */
// channel  | dir | payload                                  | transfer
// in_ch    | in  | in_char[7:0], end_of_input               | valid && ready
// out_ch   | out | out_char[7:0], is_last, status[2:0],      | valid && ready
//          |     | value_done                               |
// cfg      | in  | cfg_index[1:0], cfg_data[31:0]           | cfg_we
//
// A byte goes through accept, limit checks, then decode after the kind stack
// read; its result bytes leave through the single emit unit. A newline after an
// opening bracket or comma, or before a closing one, is followed by one tab per
// nesting level. A byte that ends a nested number is decoded a second time.
// Synchronous active-high reset; the kind stack RAM is not cleared.
// in_ch.ready is low while a byte is in work; a stalled out_ch holds the emitter.
module json_pretty_printer #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  jpp_in_if.sink                          in_ch,
  jpp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [jpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jpp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = jpp_pkg::LEVEL_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_DEC  = 9'b000000100,
    S_C0   = 9'b000001000,
    S_NL   = 9'b000010000,
    S_TAB  = 9'b000100000,
    S_C1   = 9'b001000000,
    S_ERR  = 9'b010000000,
    S_TERM = 9'b100000000
  } state_t;

  state_t            state;
  logic [7:0]        ch;
  logic              eoi;
  logic [LW-1:0]     level;
  jpp_pkg::mode_t    mode;
  logic [31:0]       bytes_in;
  logic [31:0]       bytes_out;
  jpp_pkg::status_t  error_code;
  jpp_pkg::status_t  ecode;
  logic [LW-1:0]     max_depth;
  logic [31:0]       max_in;
  logic [31:0]       max_out;

  logic [7:0]        c0;
  logic [7:0]        c1;
  logic              c1_en;
  logic              nl_en;
  logic              depth_err;
  logic              vd;
  logic [LW-1:0]     tcnt;

  logic              out_valid;
  logic [7:0]        o_char;
  logic              o_last;
  jpp_pkg::status_t  o_status;
  logic              o_vd;

  logic              kind_rd;
  logic              top_kind;
  logic [LW-1:0]     lim;
  logic              full;
  logic              room2;
  logic              obuf_free;
  logic              out_load;
  logic              stack_we;
  jpp_pkg::dec_t     dec;

  logic [7:0]        em_char;
  state_t            em_next;
  logic              em_last;

  assign lim = (max_depth > LW'(STACK_DEPTH)) ? LW'(STACK_DEPTH) : max_depth;
  assign full = (bytes_out >= max_out);
  assign room2 = ({1'b0, bytes_out} + 33'd2) <= {1'b0, max_out};
  assign obuf_free = !out_valid || out_ch.ready;
  assign out_load = obuf_free &&
                    (((state == S_C0 || state == S_NL || state == S_TAB || state == S_C1) &&
                      !full) || state == S_ERR || state == S_TERM);
  assign top_kind = (level != '0) && kind_rd;
  assign stack_we = (state == S_DEC) && !dec.err && dec.push;

  jpp_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (level[SAW-1:0]),
    .wdata (dec.push_kind),
    .raddr (SAW'(level - LW'(1))),
    .rdata (kind_rd)
  );

  jpp_decode u_dec (
    .ch    (ch),
    .mode  (mode),
    .level (level),
    .lim   (lim),
    .kind  (top_kind),
    .full  (full),
    .dec   (dec)
  );

  always_comb begin
    em_char = jpp_pkg::CH_NUL;
    em_next = S_IDLE;
    case (state)
      S_C0: begin
        em_char = c0;
        em_next = depth_err ? S_ERR : nl_en ? S_NL : c1_en ? S_C1 : S_IDLE;
      end
      S_NL: begin
        em_char = jpp_pkg::CH_NL;
        em_next = (level != '0) ? S_TAB : c1_en ? S_C1 : S_IDLE;
      end
      S_TAB: begin
        em_char = jpp_pkg::CH_TAB;
        em_next = (tcnt > LW'(1)) ? S_TAB : c1_en ? S_C1 : S_IDLE;
      end
      S_C1: begin
        em_char = c1;
        em_next = S_IDLE;
      end
      default: ;
    endcase
    em_last = (em_next == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      level      <= '0;
      mode       <= jpp_pkg::M_TOP;
      bytes_in   <= '0;
      bytes_out  <= '0;
      error_code <= jpp_pkg::ST_OK;
      max_depth  <= 6'd32;
      max_in     <= '1;
      max_out    <= '1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          jpp_pkg::CFG_MAX_DEPTH: max_depth <= cfg_data[LW-1:0];
          jpp_pkg::CFG_MAX_IN:    max_in <= cfg_data;
          jpp_pkg::CFG_MAX_OUT:   max_out <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            ch <= in_ch.in_char;
            eoi <= in_ch.end_of_input;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (error_code != jpp_pkg::ST_OK) begin
            ecode <= error_code;
            state <= S_ERR;
          end else if (eoi) begin
            if (level == '0 && (mode == jpp_pkg::M_N_ZERO || mode == jpp_pkg::M_N_INT ||
                                mode == jpp_pkg::M_N_FRAC || mode == jpp_pkg::M_N_EXP)) begin
              mode <= jpp_pkg::M_DONE;
              state <= S_TERM;
            end else if (mode == jpp_pkg::M_TOP || mode == jpp_pkg::M_VALUE ||
                         mode == jpp_pkg::M_ARR_FIRST || mode >= jpp_pkg::M_N_SIGN) begin
              ecode <= jpp_pkg::ST_NUMBER;
              state <= S_ERR;
            end else if (mode != jpp_pkg::M_DONE) begin
              ecode <= jpp_pkg::ST_SYNTAX;
              state <= S_ERR;
            end else begin
              state <= S_TERM;
            end
          end else if (mode == jpp_pkg::M_DONE) begin
            state <= S_IDLE;
          end else if (bytes_in >= max_in) begin
            ecode <= jpp_pkg::ST_IN_OVF;
            state <= S_ERR;
          end else begin
            bytes_in <= bytes_in + 32'd1;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          mode <= dec.mode_next;
          if (dec.redo) begin
            state <= S_DEC;
          end else if (dec.err) begin
            ecode <= dec.err_code;
            state <= S_ERR;
          end else begin
            if (dec.push) level <= level + LW'(1);
            if (dec.pop) level <= level - LW'(1);
            c0 <= dec.c0;
            c1 <= dec.c1;
            c1_en <= dec.c1_en;
            nl_en <= dec.nl_en;
            depth_err <= dec.depth_err;
            // a close back to top level only finishes if both bytes fit
            vd <= (dec.mode_next == jpp_pkg::M_DONE) && (!dec.is_close || room2);
            state <= dec.c0_en ? S_C0 : dec.nl_en ? S_NL : S_IDLE;
          end
        end
        S_C0, S_NL, S_TAB, S_C1: begin
          if (obuf_free) begin
            if (full) begin
              ecode <= jpp_pkg::ST_OUT_OVF;
              state <= S_ERR;
            end else begin
              o_char <= em_char;
              o_last <= em_last;
              o_status <= jpp_pkg::ST_OK;
              o_vd <= vd;
              bytes_out <= bytes_out + 32'd1;
              if (state == S_C0 && depth_err) ecode <= jpp_pkg::ST_DEPTH;
              if (state == S_NL) tcnt <= level;
              if (state == S_TAB) tcnt <= tcnt - LW'(1);
              state <= em_next;
            end
          end
        end
        S_ERR: begin
          if (obuf_free) begin
            o_char <= jpp_pkg::CH_NUL;
            o_last <= 1'b1;
            o_status <= ecode;
            o_vd <= 1'b0;
            error_code <= ecode;
            state <= S_IDLE;
          end
        end
        S_TERM: begin
          if (obuf_free) begin
            o_char <= jpp_pkg::CH_NUL;
            o_last <= 1'b1;
            o_status <= jpp_pkg::ST_OK;
            o_vd <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.out_char = o_char;
  assign out_ch.is_last = o_last;
  assign out_ch.status = o_status;
  assign out_ch.value_done = o_vd;

`ifndef NO_ASSERTIONS
  a_err_latched: assert property (@(posedge clk) disable iff (rst)
    (error_code != jpp_pkg::ST_OK) |=> (error_code == $past(error_code)))
    else $error("latched error code changed");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LW'(STACK_DEPTH))
    else $error("nesting level beyond stack");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_status != jpp_pkg::ST_OK) |-> (o_last && !o_vd))
    else $error("error result not final");

  a_push_in_range: assert property (@(posedge clk) disable iff (rst)
    stack_we |-> (level < lim))
    else $error("push past depth limit");
`endif
endmodule

/* bench/json_pretty_printer_tb.sv */
module json_pretty_printer_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic [2:0] st;
    logic       done;
  } res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       chk;
    logic [7:0] first;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [jpp_pkg::CFG_IDX_W-1:0] cfg_index = jpp_pkg::CFG_MAX_DEPTH;
  logic [jpp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  jpp_in_if  in_bus ();
  jpp_out_if out_bus ();

  json_pretty_printer uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // printer state mirror
  logic [31:0]       kinds;
  logic [5:0]        lvl;
  jpp_pkg::mode_t    mode;
  logic [31:0]       nin, nout;
  jpp_pkg::status_t  ecode;
  logic [5:0]        lim_depth;
  logic [31:0]       lim_in, lim_out;

  res_t step_q[$];
  res_t pending_q[$];
  logic [7:0] txt[$];

  int  errs = 0;
  int  quiet = 0;
  bit  idle_on = 1'b1;
  int  rdy_hold = 0;

  function automatic void put(logic [7:0] c, logic [2:0] st);
    step_q.push_back('{ch: c, last: 1'b0, st: st, done: 1'b0});
  endfunction

  function automatic void raise_st(jpp_pkg::status_t s);
    if (ecode == jpp_pkg::ST_OK) ecode = s;
  endfunction

  function automatic void syntax_fail();
    raise_st((nout >= lim_out) ? jpp_pkg::ST_OUT_OVF : jpp_pkg::ST_SYNTAX);
  endfunction

  function automatic bit emit_ch(logic [7:0] c);
    if (ecode != jpp_pkg::ST_OK) return 1'b0;
    if (nout >= lim_out) begin
      raise_st(jpp_pkg::ST_OUT_OVF);
      return 1'b0;
    end
    put(c, jpp_pkg::ST_OK);
    nout++;
    return 1'b1;
  endfunction

  function automatic void newline();
    if (!emit_ch(jpp_pkg::CH_NL)) return;
    for (int i = 0; i < lvl; i++)
      if (!emit_ch(jpp_pkg::CH_TAB)) return;
  endfunction

  function automatic logic top_kind();
    if (lvl == 0) return 1'b0;
    return kinds[lvl - 1];
  endfunction

  function automatic void finish_value();
    mode = (lvl == 0) ? jpp_pkg::M_DONE : jpp_pkg::M_AFTER;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= jpp_pkg::CH_ZERO && c <= jpp_pkg::CH_NINE;
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == jpp_pkg::CH_SPACE || c == jpp_pkg::CH_TAB || c == jpp_pkg::CH_NL ||
           c == jpp_pkg::CH_VT || c == jpp_pkg::CH_FF || c == jpp_pkg::CH_CR;
  endfunction

  function automatic logic [7:0] lit_ch(int k);
    case (k)
      0: return jpp_pkg::CH_U;
      1: return jpp_pkg::CH_L;
      2: return jpp_pkg::CH_L;
      3: return jpp_pkg::CH_R;
      4: return jpp_pkg::CH_U;
      5: return jpp_pkg::CH_E;
      6: return jpp_pkg::CH_A;
      7: return jpp_pkg::CH_L;
      8: return jpp_pkg::CH_S;
      default: return jpp_pkg::CH_E;
    endcase
  endfunction

  function automatic void open_box(logic [7:0] c, logic kind);
    int lim;
    lim = (lim_depth > 32) ? 32 : lim_depth;
    if (!emit_ch(c)) return;
    if (lvl + 1 > lim) begin
      raise_st(jpp_pkg::ST_DEPTH);
      return;
    end
    kinds[lvl] = kind;
    lvl++;
    mode = kind ? jpp_pkg::M_OBJ_FIRST : jpp_pkg::M_ARR_FIRST;
    newline();
  endfunction

  function automatic void close_box();
    logic k;
    k = top_kind();
    if (lvl > 0) lvl--;
    newline();
    if (emit_ch(k ? jpp_pkg::CH_CBRACE : jpp_pkg::CH_CBRK)) finish_value();
  endfunction

  function automatic void value_begin(logic [7:0] c);
    if (c == jpp_pkg::CH_OBRACE) open_box(c, 1'b1);
    else if (c == jpp_pkg::CH_OBRK) open_box(c, 1'b0);
    else if (c == jpp_pkg::CH_QUOTE) begin if (emit_ch(c)) mode = jpp_pkg::M_STR; end
    else if (c == jpp_pkg::CH_N) begin if (emit_ch(c)) mode = jpp_pkg::M_NULL_U; end
    else if (c == jpp_pkg::CH_T) begin if (emit_ch(c)) mode = jpp_pkg::M_TRUE_R; end
    else if (c == jpp_pkg::CH_F) begin if (emit_ch(c)) mode = jpp_pkg::M_FALSE_A; end
    else if (c == jpp_pkg::CH_MINUS) begin if (emit_ch(c)) mode = jpp_pkg::M_N_SIGN; end
    else if (c == jpp_pkg::CH_ZERO) begin if (emit_ch(c)) mode = jpp_pkg::M_N_ZERO; end
    else if (is_digit(c)) begin if (emit_ch(c)) mode = jpp_pkg::M_N_INT; end
    else raise_st(jpp_pkg::ST_NUMBER);
  endfunction

  // returns 1 when the byte closed a nested number and must be parsed again
  function automatic bit number_char(logic [7:0] c);
    jpp_pkg::mode_t m;
    bit dig, ex;
    m = mode;
    dig = is_digit(c);
    ex = (c == jpp_pkg::CH_E || c == jpp_pkg::CH_UPPER_E);
    case (m)
      jpp_pkg::M_N_SIGN: begin
        if (!dig) begin raise_st(jpp_pkg::ST_NUMBER); return 1'b0; end
        if (emit_ch(c)) mode = (c == jpp_pkg::CH_ZERO) ? jpp_pkg::M_N_ZERO : jpp_pkg::M_N_INT;
        return 1'b0;
      end
      jpp_pkg::M_N_ZERO, jpp_pkg::M_N_INT: begin
        if (dig) begin
          if (m == jpp_pkg::M_N_ZERO) raise_st(jpp_pkg::ST_NUMBER);
          else void'(emit_ch(c));
          return 1'b0;
        end
        if (c == jpp_pkg::CH_DOT) begin
          if (emit_ch(c)) mode = jpp_pkg::M_N_FRAC0;
          return 1'b0;
        end
        if (ex) begin if (emit_ch(c)) mode = jpp_pkg::M_N_EXP0; return 1'b0; end
      end
      jpp_pkg::M_N_FRAC0: begin
        if (!dig) begin raise_st(jpp_pkg::ST_NUMBER); return 1'b0; end
        if (emit_ch(c)) mode = jpp_pkg::M_N_FRAC;
        return 1'b0;
      end
      jpp_pkg::M_N_FRAC: begin
        if (dig) begin void'(emit_ch(c)); return 1'b0; end
        if (ex) begin if (emit_ch(c)) mode = jpp_pkg::M_N_EXP0; return 1'b0; end
      end
      jpp_pkg::M_N_EXP0: begin
        if (c == jpp_pkg::CH_PLUS || c == jpp_pkg::CH_MINUS) begin
          if (emit_ch(c)) mode = jpp_pkg::M_N_EXPS;
          return 1'b0;
        end
        if (!dig) begin raise_st(jpp_pkg::ST_NUMBER); return 1'b0; end
        if (emit_ch(c)) mode = jpp_pkg::M_N_EXP;
        return 1'b0;
      end
      jpp_pkg::M_N_EXPS: begin
        if (!dig) begin raise_st(jpp_pkg::ST_NUMBER); return 1'b0; end
        if (emit_ch(c)) mode = jpp_pkg::M_N_EXP;
        return 1'b0;
      end
      default: begin
        if (dig) begin void'(emit_ch(c)); return 1'b0; end
      end
    endcase
    finish_value();
    return mode == jpp_pkg::M_AFTER;
  endfunction

  function automatic bit parse_char(logic [7:0] c);
    jpp_pkg::mode_t m;
    int k;
    logic kind;
    m = mode;
    if (m >= jpp_pkg::M_N_SIGN) return number_char(c);
    if (m >= jpp_pkg::M_NULL_U) begin
      k = m - jpp_pkg::M_NULL_U;
      if (c != lit_ch(k)) begin syntax_fail(); return 1'b0; end
      if (emit_ch(c)) begin
        if (k == 2 || k == 5 || k == 9) finish_value();
        else mode = jpp_pkg::mode_t'(m + 1);
      end
      return 1'b0;
    end
    case (m)
      jpp_pkg::M_STR, jpp_pkg::M_KEYSTR: begin
        if (!emit_ch(c)) return 1'b0;
        if (c == jpp_pkg::CH_BSLASH) mode = jpp_pkg::mode_t'(m + 1);
        else if (c == jpp_pkg::CH_QUOTE) begin
          if (m == jpp_pkg::M_STR) finish_value();
          else mode = jpp_pkg::M_COLON;
        end
        return 1'b0;
      end
      jpp_pkg::M_STR_ESC, jpp_pkg::M_KEYSTR_ESC: begin
        if (emit_ch(c)) mode = jpp_pkg::mode_t'(m - 1);
        return 1'b0;
      end
      default: ;
    endcase
    if (is_ws(c)) return 1'b0;
    case (m)
      jpp_pkg::M_TOP, jpp_pkg::M_VALUE: value_begin(c);
      jpp_pkg::M_ARR_FIRST: begin
        if (c == jpp_pkg::CH_CBRK) close_box();
        else value_begin(c);
      end
      jpp_pkg::M_OBJ_FIRST, jpp_pkg::M_KEY: begin
        if (m == jpp_pkg::M_OBJ_FIRST && c == jpp_pkg::CH_CBRACE) close_box();
        else if (c != jpp_pkg::CH_QUOTE) syntax_fail();
        else if (emit_ch(c)) mode = jpp_pkg::M_KEYSTR;
      end
      jpp_pkg::M_COLON: begin
        if (c != jpp_pkg::CH_COLON) syntax_fail();
        else if (emit_ch(c) && emit_ch(jpp_pkg::CH_SPACE)) mode = jpp_pkg::M_VALUE;
      end
      jpp_pkg::M_AFTER: begin
        kind = top_kind();
        if (c == (kind ? jpp_pkg::CH_CBRACE : jpp_pkg::CH_CBRK)) close_box();
        else if (c != jpp_pkg::CH_COMMA) syntax_fail();
        else if (emit_ch(c)) begin
          mode = kind ? jpp_pkg::M_KEY : jpp_pkg::M_VALUE;
          newline();
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void predict_step(logic [7:0] c, logic eoi);
    jpp_pkg::mode_t m;
    step_q.delete();
    if (ecode != jpp_pkg::ST_OK) begin
      put(jpp_pkg::CH_NUL, ecode);
      step_q[0].last = 1'b1;
    end else begin
      if (eoi) begin
        m = mode;
        if (lvl == 0 && (m == jpp_pkg::M_N_ZERO || m == jpp_pkg::M_N_INT ||
                         m == jpp_pkg::M_N_FRAC || m == jpp_pkg::M_N_EXP))
          mode = jpp_pkg::M_DONE;
        else if (m == jpp_pkg::M_TOP || m == jpp_pkg::M_VALUE ||
                 m == jpp_pkg::M_ARR_FIRST || m >= jpp_pkg::M_N_SIGN)
          raise_st(jpp_pkg::ST_NUMBER);
        else if (m != jpp_pkg::M_DONE)
          raise_st(jpp_pkg::ST_SYNTAX);
        if (ecode == jpp_pkg::ST_OK) put(jpp_pkg::CH_NUL, jpp_pkg::ST_OK);
      end else if (mode != jpp_pkg::M_DONE) begin
        if (nin >= lim_in) raise_st(jpp_pkg::ST_IN_OVF);
        else begin
          nin++;
          if (parse_char(c)) void'(parse_char(c));
        end
      end
      if (ecode != jpp_pkg::ST_OK) begin
        put(jpp_pkg::CH_NUL, ecode);
        step_q[step_q.size() - 1].last = 1'b1;
      end else if (step_q.size() > 0) begin
        foreach (step_q[i]) step_q[i].done = (mode == jpp_pkg::M_DONE);
        step_q[step_q.size() - 1].last = 1'b1;
      end
    end
    foreach (step_q[i]) pending_q.push_back(step_q[i]);
  endfunction

  task automatic flag(string what, res_t want, res_t got);
    errs++;
    if (errs <= 10)
      $display("%0t %s: want ch=%02h last=%0d st=%0d done=%0d, got ch=%02h last=%0d st=%0d done=%0d",
               $time, what, want.ch, want.last, want.st, want.done,
               got.ch, got.last, got.st, got.done);
  endtask

  // output side: random stalls, checker
  always @(posedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold--;
      out_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rdy_hold = $urandom_range(0, 8);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      got = '{ch: out_bus.out_char, last: out_bus.is_last, st: out_bus.status,
              done: out_bus.value_done};
      if (pending_q.size() == 0) flag("unexpected transfer", '0, got);
      else begin
        want = pending_q.pop_front();
        if (got.ch !== want.ch || got.last !== want.last || got.st !== want.st ||
            got.done !== want.done)
          flag("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
    else if (++quiet >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(logic [7:0] c, logic eoi);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.in_char <= c;
    in_bus.end_of_input <= eoi;
    do @(posedge clk); while (!in_bus.ready);
    predict_step(c, eoi);
  endtask

  task automatic send_text();
    foreach (txt[i]) send_item(txt[i], 1'b0);
    txt.delete();
  endtask

  // sender holds off until the printer has drained and gone quiet
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [jpp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      jpp_pkg::CFG_MAX_DEPTH: lim_depth = val[5:0];
      jpp_pkg::CFG_MAX_IN:    lim_in = val;
      default:                lim_out = val;
    endcase
  endtask

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(0, 5))
      0: return jpp_pkg::CH_SPACE;
      1: return jpp_pkg::CH_TAB;
      2: return jpp_pkg::CH_NL;
      3: return jpp_pkg::CH_VT;
      4: return jpp_pkg::CH_FF;
      default: return jpp_pkg::CH_CR;
    endcase
  endfunction

  function automatic void gen_ws();
    if ($urandom_range(0, 4) == 0) txt.push_back(ws_byte());
  endfunction

  function automatic void gen_string();
    logic [7:0] c;
    txt.push_back(jpp_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 7) == 0) begin
        txt.push_back(jpp_pkg::CH_BSLASH);
        txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (c == jpp_pkg::CH_QUOTE || c == jpp_pkg::CH_BSLASH);
        txt.push_back(c);
      end
    end
    txt.push_back(jpp_pkg::CH_QUOTE);
  endfunction

  function automatic void gen_digit(logic [7:0] lo);
    txt.push_back(8'($urandom_range(lo, jpp_pkg::CH_NINE)));
  endfunction

  function automatic void gen_number();
    if ($urandom_range(0, 1)) txt.push_back(jpp_pkg::CH_MINUS);
    if ($urandom_range(0, 3) == 0) txt.push_back(jpp_pkg::CH_ZERO);
    else begin
      gen_digit(jpp_pkg::CH_ZERO + 8'd1);
      repeat ($urandom_range(0, 3)) gen_digit(jpp_pkg::CH_ZERO);
    end
    if ($urandom_range(0, 1)) begin
      txt.push_back(jpp_pkg::CH_DOT);
      repeat ($urandom_range(1, 3)) gen_digit(jpp_pkg::CH_ZERO);
    end
    if ($urandom_range(0, 2) == 0) begin
      txt.push_back($urandom_range(0, 1) ? jpp_pkg::CH_E : jpp_pkg::CH_UPPER_E);
      case ($urandom_range(0, 2))
        0: txt.push_back(jpp_pkg::CH_PLUS);
        1: txt.push_back(jpp_pkg::CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) gen_digit(jpp_pkg::CH_ZERO);
    end
  endfunction

  function automatic void gen_value(int depth);
    int r, n;
    bit obj;
    r = $urandom_range(0, 9);
    if (r <= 2 && depth < 6) begin
      obj = (r == 0);
      txt.push_back(obj ? jpp_pkg::CH_OBRACE : jpp_pkg::CH_OBRK);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        gen_ws();
        if (obj) begin
          gen_string();
          gen_ws();
          txt.push_back(jpp_pkg::CH_COLON);
          gen_ws();
        end
        gen_value(depth + 1);
        gen_ws();
        if (i != n - 1) txt.push_back(jpp_pkg::CH_COMMA);
      end
      gen_ws();
      txt.push_back(obj ? jpp_pkg::CH_CBRACE : jpp_pkg::CH_CBRK);
    end else if (r <= 4) gen_string();
    else if (r <= 7) gen_number();
    else begin
      case ($urandom_range(0, 2))
        0: begin
          txt.push_back(jpp_pkg::CH_N); txt.push_back(jpp_pkg::CH_U);
          txt.push_back(jpp_pkg::CH_L); txt.push_back(jpp_pkg::CH_L);
        end
        1: begin
          txt.push_back(jpp_pkg::CH_T); txt.push_back(jpp_pkg::CH_R);
          txt.push_back(jpp_pkg::CH_U); txt.push_back(jpp_pkg::CH_E);
        end
        default: begin
          txt.push_back(jpp_pkg::CH_F); txt.push_back(jpp_pkg::CH_A);
          txt.push_back(jpp_pkg::CH_L); txt.push_back(jpp_pkg::CH_S);
          txt.push_back(jpp_pkg::CH_E);
        end
      endcase
    end
  endfunction

  // one key/value pair inside the top object
  function automatic void gen_member(bit comma);
    gen_string();
    gen_ws();
    txt.push_back(jpp_pkg::CH_COLON);
    gen_ws();
    gen_value(1);
    gen_ws();
    if (comma) txt.push_back(jpp_pkg::CH_COMMA);
  endfunction

  dir_row_t dir_tab[25] = '{
    '{jpp_pkg::CH_OBRACE, 1'b1, jpp_pkg::CH_OBRACE},
    '{jpp_pkg::CH_SPACE, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_QUOTE, 1'b1, jpp_pkg::CH_QUOTE},
    '{jpp_pkg::CH_BSLASH, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_QUOTE, 1'b0, jpp_pkg::CH_NUL},
    '{8'hFF, 1'b0, jpp_pkg::CH_NUL},
    '{8'h00, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_QUOTE, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_TAB, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_COLON, 1'b1, jpp_pkg::CH_COLON},
    '{jpp_pkg::CH_OBRK, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_MINUS, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_ZERO, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_DOT, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_NINE, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_UPPER_E, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_PLUS, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_NINE, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_COMMA, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_T, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_R, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_U, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_E, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_CBRK, 1'b0, jpp_pkg::CH_NUL},
    '{jpp_pkg::CH_COMMA, 1'b0, jpp_pkg::CH_NUL}
  };

  initial begin
    int ending;
    in_bus.valid = 1'b0;
    in_bus.in_char = '0;
    in_bus.end_of_input = 1'b0;
    out_bus.ready = 1'b0;
    kinds = '0;
    lvl = '0;
    mode = jpp_pkg::M_TOP;
    nin = '0;
    nout = '0;
    ecode = jpp_pkg::ST_OK;
    lim_depth = 6'd32;
    lim_in = '1;
    lim_out = '1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_write(jpp_pkg::CFG_MAX_DEPTH, 32'd32);
    cfg_write(jpp_pkg::CFG_MAX_IN, 32'hFFFF_FFFF);
    cfg_write(jpp_pkg::CFG_MAX_OUT, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;

    // directed opening: escapes, raw 00/FF inside a key, a full number, a nested
    // number ended by a comma, a literal, whitespace outside strings
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].ch, 1'b0);
      if (dir_tab[i].chk && (step_q.size() == 0 || step_q[0].ch !== dir_tab[i].first))
        flag("directed first byte", '{dir_tab[i].first, 1'b0, jpp_pkg::ST_OK, 1'b0},
             step_q.size() ? step_q[0] : '0);
    end
    settle();

    // depth register above the stack size acts as the stack size
    cfg_write(jpp_pkg::CFG_MAX_DEPTH, 32'd63);
    cfg_write(jpp_pkg::CFG_MAX_IN, 32'h8000_0000);
    cfg_write(jpp_pkg::CFG_MAX_OUT, 32'h7FFF_FFFF);
    cfg_we <= 1'b0;
    // one value nested to the full stack: widest tab bursts
    gen_string();
    txt.push_back(jpp_pkg::CH_COLON);
    repeat (31) txt.push_back(jpp_pkg::CH_OBRK);
    txt.push_back(jpp_pkg::CH_ZERO);
    repeat (31) txt.push_back(jpp_pkg::CH_CBRK);
    txt.push_back(jpp_pkg::CH_COMMA);
    while (txt.size() < 170) gen_member(1'b1);
    send_text();
    settle();

    cfg_write(jpp_pkg::CFG_MAX_DEPTH, 32'd32);
    cfg_write(jpp_pkg::CFG_MAX_IN, 32'hFFFF_FFFF);
    cfg_write(jpp_pkg::CFG_MAX_OUT, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    idle_on = 1'b0;
    while (txt.size() < 140) gen_member(1'b1);
    send_text();

    ending = $urandom_range(0, 5);
    if (ending == 1 || ending == 2 || ending == 3) begin
      settle();
      case (ending)
        1: cfg_write(jpp_pkg::CFG_MAX_DEPTH, 32'd1);
        2: cfg_write(jpp_pkg::CFG_MAX_IN, nin);
        default: cfg_write(jpp_pkg::CFG_MAX_OUT, nout + $urandom_range(1, 20));
      endcase
      cfg_we <= 1'b0;
    end
    case (ending)
      0: begin
        gen_member(1'b0);
        txt.push_back(jpp_pkg::CH_CBRACE);
      end
      1: begin
        gen_string();
        txt.push_back(jpp_pkg::CH_COLON);
        txt.push_back(jpp_pkg::CH_OBRK);
      end
      4: txt.push_back(jpp_pkg::CH_A);
      5: begin
        gen_string();
        txt.push_back(jpp_pkg::CH_COLON);
        txt.push_back(jpp_pkg::CH_PLUS);
      end
      default: while (txt.size() < 40) gen_member(1'b1);
    endcase
    send_text();
    // after the end or an error: ignored bytes or the latched status
    repeat (3) send_item(8'($urandom_range(0, 255)), 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    settle();

    if (errs == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/jpp_pkg.sv
hw/rtl/jpp_if.sv
hw/rtl/jpp_ram.sv
hw/rtl/jpp_decode.sv
hw/rtl/json_pretty_printer.sv
bench/json_pretty_printer_tb.sv
